FILE: design/pcmf_pkg.sv
package pcmf_pkg;

  localparam logic [31:0] MagEight = 32'h4100_0000;

  typedef enum logic [2:0] {
    MODE_FLOAT32,
    MODE_INT8,
    MODE_INT16,
    MODE_INT24,
    MODE_INT32,
    MODE_UNSUP
  } mode_t;

  // decoded item between the input stage and the output stage
  typedef struct packed {
    mode_t       mode;
    logic [31:0] word;
  } stage_t;

  typedef struct packed {
    logic [31:0] sample_float;
    logic        status;
  } result_t;

endpackage

FILE: design/pcm_sample_to_float_decoder.sv
// an input transaction passes the input register and then the result register before output valid
// throughput: one transaction per cycle while the output is not stalled, with no bubbles
// the path is set by the integer normalize and round in pcmf_convert
// reset: synchronous active high, empties both stages, sample_format 0, sample_bits 16
module pcm_sample_to_float_decoder (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // raw_word[31:0]
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // sample_float[31:0]
  output logic        m_axis_tuser    // status
);

  logic                sample_format;
  logic [5:0]          sample_bits;
  pcmf_pkg::mode_t     mode_sel;
  pcmf_pkg::stage_t    stage;
  logic                stage_valid;
  pcmf_pkg::result_t   result;
  logic                out_valid;
  pcmf_pkg::result_t   out_data;
  logic                out_free;
  logic                stage_free;

  assign cfg_ready = 1'b1;

  // register index 0 sample_format, 1 sample_bits
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= 1'b0;
      sample_bits   <= 6'd16;
    end else if (cfg_valid) begin
      if (cfg_index) sample_bits <= cfg_data;
      else sample_format <= cfg_data[0];
    end
  end

  // pick the decode mode from the configuration
  always_comb begin
    mode_sel = pcmf_pkg::MODE_UNSUP;
    if (sample_format) begin
      if (sample_bits == 6'd32) mode_sel = pcmf_pkg::MODE_FLOAT32;
    end else begin
      case (sample_bits)
        6'd8:    mode_sel = pcmf_pkg::MODE_INT8;
        6'd16:   mode_sel = pcmf_pkg::MODE_INT16;
        6'd24:   mode_sel = pcmf_pkg::MODE_INT24;
        6'd32:   mode_sel = pcmf_pkg::MODE_INT32;
        default: mode_sel = pcmf_pkg::MODE_UNSUP;
      endcase
    end
  end

  // pipeline advances when the next stage is empty or draining
  assign out_free      = ~out_valid | m_axis_tready;
  assign stage_free    = ~stage_valid | out_free;
  assign s_axis_tready = stage_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) stage_valid <= 1'b0;
    else if (stage_free) stage_valid <= s_axis_tvalid;
  end

  always_ff @(posedge clk) begin
    if (stage_free && s_axis_tvalid) begin
      stage.mode <= mode_sel;
      stage.word <= s_axis_tdata;
    end
  end

  pcmf_convert u_convert (
    .stage  (stage),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_free) out_valid <= stage_valid;
  end

  always_ff @(posedge clk) begin
    if (out_free && stage_valid) out_data <= result;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data.sample_float;
  assign m_axis_tuser  = out_data.status;

endmodule

FILE: design/pcmf_convert.sv
module pcmf_convert (
  input  pcmf_pkg::stage_t  stage,
  output pcmf_pkg::result_t result
);

  logic        neg;
  logic [31:0] mag;
  logic [4:0]  scale;
  logic [4:0]  p;
  logic [31:0] norm;
  logic [24:0] mant;
  logic        rnd;
  logic [7:0]  expo;
  logic [30:0] fmag;

  // sign and magnitude of the integer sample
  always_comb begin
    neg   = 1'b0;
    mag   = '0;
    scale = 5'd0;
    case (stage.mode)
      pcmf_pkg::MODE_INT8: begin
        neg   = ~stage.word[7];
        mag   = stage.word[7] ? {24'd0, 1'b0, stage.word[6:0]}
                              : 32'd128 - {24'd0, stage.word[7:0]};
        scale = 5'd7;
      end
      pcmf_pkg::MODE_INT16: begin
        neg   = stage.word[15];
        mag   = neg ? 32'h0001_0000 - {16'd0, stage.word[15:0]}
                    : {16'd0, stage.word[15:0]};
        scale = 5'd15;
      end
      pcmf_pkg::MODE_INT24: begin
        neg   = stage.word[23];
        mag   = neg ? 32'h0100_0000 - {8'd0, stage.word[23:0]}
                    : {8'd0, stage.word[23:0]};
        scale = 5'd23;
      end
      pcmf_pkg::MODE_INT32: begin
        neg   = stage.word[31];
        mag   = neg ? 32'd0 - stage.word : stage.word;
        scale = 5'd31;
      end
      default: ;
    endcase
  end

  // leading one search and normalize
  always_comb begin
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) p = 5'(i);
    end
    norm = mag << (5'd31 - p);
    // guard bit norm[7], sticky norm[6:0]
    rnd  = norm[7] & ((|norm[6:0]) | norm[8]);
    mant = {1'b0, norm[31:8]} + {24'd0, rnd};
    expo = 8'd127 + {3'd0, p} - {3'd0, scale} + {7'd0, mant[24]};
  end

  assign fmag = stage.word[30:0];

  always_comb begin
    result.status       = 1'b0;
    result.sample_float = '0;
    case (stage.mode)
      pcmf_pkg::MODE_FLOAT32: begin
        if (fmag[30:23] == 8'hFF) result.sample_float = '0;
        else if ({1'b0, fmag} > pcmf_pkg::MagEight)
          result.sample_float = {stage.word[31], pcmf_pkg::MagEight[30:0]};
        else result.sample_float = stage.word;
      end
      pcmf_pkg::MODE_UNSUP: result.status = 1'b1;
      default: begin
        if (mag != 32'd0)
          result.sample_float = {neg, expo,
                                 mant[24] ? mant[23:1] : mant[22:0]};
      end
    endcase
  end

endmodule

FILE: design/pcmf_checker.sv
module pcmf_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // stalled output holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");

  // unsupported gives zero
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("unsupported result not zero");

  // never infinity or nan
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[30:23] != 8'hFF)
    else $error("non-finite result");

  // magnitude at most eight
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[30:0] <= 31'h4100_0000)
    else $error("result above eight");

endmodule

bind pcm_sample_to_float_decoder pcmf_checker u_pcmf_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: verif/tb_pcm_sample_to_float_decoder.sv
module tb_pcm_sample_to_float_decoder;

  // register indexes of the configuration channel
  localparam logic RegFormat = 1'b0;
  localparam logic RegBits   = 1'b1;
  localparam int   StallCap  = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [5:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;   // sample_float[31:0]
  logic        m_axis_tuser;   // status

  pcm_sample_to_float_decoder dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #1 clk = ~clk;

  // shadow copy of the block's registers
  logic       fmt_shadow;
  logic [5:0] bits_shadow;

  pcmf_pkg::result_t pending_samples[$];
  int      mismatches = 0;
  int      send_idle_pct = 0;  // percent of cycles the sender idles
  int      recv_idle_pct = 0;  // percent of cycles the receiver stalls
  bit      hold_off = 1'b0;    // long receiver stall request
  int      quiet_cycles = 0;

  // scaled signed integer to single precision, round to nearest even
  function automatic logic [31:0] scaled_int_to_single(logic neg, logic [31:0] mag,
                                                       int unsigned scale_exp);
    int          msb;
    int          sh;
    logic [32:0] mant;
    logic [31:0] rem;
    logic [31:0] half;
    logic [7:0]  expo;
    msb = 31;
    if (mag == 0) return 32'h0;
    while (!mag[msb]) msb--;
    if (msb <= 23) begin
      mant = {1'b0, mag} << (23 - msb);
    end else begin
      sh = msb - 23;
      rem = mag & ((32'h1 << sh) - 1);
      half = 32'h1 << (sh - 1);
      mant = {1'b0, mag >> sh};
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant == 33'h100_0000) begin
        mant = mant >> 1;
        msb++;
      end
    end
    expo = 8'(msb + 127 - scale_exp);
    return {neg, expo, mant[22:0]};
  endfunction

  function automatic pcmf_pkg::result_t decode_sample(logic [31:0] w);
    pcmf_pkg::result_t r;
    r.status = 1'b0;
    r.sample_float = '0;
    if (fmt_shadow && bits_shadow == 6'd32) begin
      if (w[30:23] == 8'hFF) r.sample_float = '0;          // inf and nan go to zero
      else if (w[30:0] > pcmf_pkg::MagEight[30:0])
        r.sample_float = {w[31], pcmf_pkg::MagEight[30:0]};
      else r.sample_float = w;
    end else if (!fmt_shadow && bits_shadow == 6'd8) begin
      // offset binary around 128
      if (w[7:0] >= 8'd128) r.sample_float = scaled_int_to_single(1'b0, w[7:0] - 32'd128, 7);
      else r.sample_float = scaled_int_to_single(1'b1, 32'd128 - w[7:0], 7);
    end else if (!fmt_shadow && bits_shadow == 6'd16) begin
      if (w[15]) r.sample_float = scaled_int_to_single(1'b1, 32'h10000 - w[15:0], 15);
      else r.sample_float = scaled_int_to_single(1'b0, {16'h0, w[15:0]}, 15);
    end else if (!fmt_shadow && bits_shadow == 6'd24) begin
      if (w[23]) r.sample_float = scaled_int_to_single(1'b1, 32'h100_0000 - w[23:0], 23);
      else r.sample_float = scaled_int_to_single(1'b0, {8'h0, w[23:0]}, 23);
    end else if (!fmt_shadow && bits_shadow == 6'd32) begin
      if (w[31]) r.sample_float = scaled_int_to_single(1'b1, 32'h0 - w, 31);
      else r.sample_float = scaled_int_to_single(1'b0, w, 31);
    end else begin
      r.status = 1'b1;
    end
    return r;
  endfunction

  // receiver ready, driven at the falling edge
  int hold_count = 0;
  always @(negedge clk) begin
    if (hold_off && hold_count < 300) begin
      hold_count <= hold_count + 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (!hold_off) hold_count <= 0;
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker: compares each output transaction with the oldest prediction
  always @(posedge clk) begin
    pcmf_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output transaction data=%h status=%b", m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_samples.pop_front();
        if (want.sample_float !== m_axis_tdata || want.status !== m_axis_tuser) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b got %h/%b", want.sample_float, want.status,
                     m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallCap) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);   // margin past the two-stage pipeline
  endtask

  task automatic write_reg(logic idx, logic [5:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == RegFormat) fmt_shadow = value[0];
    else bits_shadow = value;
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
  endtask

  // input goes idle before the pipeline drains and the registers change
  task automatic set_mode(logic fmt, logic [5:0] nbits);
    end_burst();
    wait_drained();
    write_reg(RegFormat, {5'b0, fmt});
    write_reg(RegBits, nbits);
  endtask

  // offers one sample, holding tvalid high across back-to-back items
  task automatic send_sample(logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_samples = {pending_samples, decode_sample(w)};
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_float();
    case ($urandom_range(5))
      0: return {1'($urandom_range(1)), 8'hFF, 23'($urandom)};          // inf or nan
      1: return {1'($urandom_range(1)), 8'h00, 23'($urandom)};          // subnormal
      2: return {1'($urandom_range(1)), 8'($urandom_range(120, 133)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    set_mode(1'b0, 6'd16);   // reset value kept
    send_sample(32'h0000_0000); send_sample(32'hFFFF_7FFF); send_sample(32'h0000_8000);
    send_sample(32'h0000_FFFF);
    set_mode(1'b0, 6'd8);
    send_sample(32'hFFFF_FF00); send_sample(32'h0000_0080); send_sample(32'h0000_00FF);
    set_mode(1'b0, 6'd24);
    send_sample(32'h0080_0000); send_sample(32'hFF7F_FFFF); send_sample(32'h0000_0001);
    set_mode(1'b0, 6'd32);
    send_sample(32'h8000_0000); send_sample(32'h7FFF_FFFF); send_sample(32'h0000_0181);
    send_sample(32'h0000_0000);
    set_mode(1'b1, 6'd32);
    send_sample(32'h8000_0000); send_sample(32'h0000_0001); send_sample(32'h7F80_0000);
    send_sample(32'hFFC0_0001); send_sample(32'h4100_0001); send_sample(32'hC2000000);
    send_sample(32'h4100_0000);
    set_mode(1'b1, 6'd16);   // unsupported
    send_sample(32'h1234_5678);
    set_mode(1'b0, 6'd63);
    send_sample(32'hFFFF_FFFF);
    set_mode(1'b0, 6'd0);
    send_sample(32'h0);
  endtask

  task automatic test_random(int n);
    int          k;
    logic        fmt;
    logic [5:0]  nbits;
    for (k = 0; k < n; k++) begin
      if (k % 60 == 0) begin
        fmt = 1'($urandom_range(1));
        case ($urandom_range(5))
          0: nbits = 6'd8;
          1: nbits = 6'd16;
          2: nbits = 6'd24;
          3, 4: nbits = 6'd32;
          default: nbits = 6'($urandom);
        endcase
        set_mode(fmt, nbits);
      end
      send_sample(fmt ? random_float() : $urandom);
    end
  endtask

  task automatic test_backpressure();
    int k;
    set_mode(1'b0, 6'd32);
    hold_off = 1'b1;   // receiver holds off while the sender keeps offering
    for (k = 0; k < 40; k++) send_sample($urandom);
    hold_off = 1'b0;
    end_burst();
    wait_drained();    // sender pauses until everything is back
    for (k = 0; k < 10; k++) send_sample($urandom);
    end_burst();
  endtask

  initial begin
    fmt_shadow = 1'b0;
    bits_shadow = 6'd16;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    send_idle_pct = 38; recv_idle_pct = 52;
    test_random(440);
    send_idle_pct = 52; recv_idle_pct = 38;
    test_random(440);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(400);
    test_backpressure();
    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending_samples.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
design/pcmf_pkg.sv
design/pcmf_convert.sv
design/pcm_sample_to_float_decoder.sv
design/pcmf_checker.sv
verif/tb_pcm_sample_to_float_decoder.sv
